[hw/rtl/tfdc_pkg.sv]
// Package for the tagged frame deframer/checker.
// Holds payload structs, config indexes and size constants. No dependencies.
package tfdc_pkg;
	localparam int BufferDepthDef = 128;
	localparam int MinFrameDef = 5;
	localparam int LenLimit = 32;
	localparam logic [7:0] CmdLimit = 8'h20;
	localparam logic [7:0] IdLimit = 8'h50;
	localparam logic [7:0] IndLenA = 8'd9;
	localparam logic [7:0] IndLenB = 8'd13;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 16;
	localparam logic [CfgIdxW-1:0] CFG_REQ_TAG = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_RSP_TAG = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_ANY_TAG = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_IND_CMD = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_TIMEOUT = 3'd4;
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic       operation;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic [4:0] frame_length;
		logic       last_byte;
		logic       checksum_ok;
	} out_item_t;
endpackage

[hw/rtl/tfdc_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module tfdc_ram #(
	parameter int Width = 8,
	parameter int Depth = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hw/rtl/tagged_frame_deframer_checker.sv]
// Tagged frame deframer/checker top level.
// Uses tfdc_pkg and tfdc_ram (receive buffer).
//
// Usage: input items (a received byte or one idle tick) arrive on
// in_valid/in_stall; frame bytes leave on out_valid/out_stall, one transfer
// per byte, with frame_length on every byte and last_byte/checksum_ok on
// the final one. Write registers through cfg_we/cfg_index/cfg_data only
// while the block is idle; the block itself does not enforce this.
// A small sequencer drives one buffer RAM read port and one compare unit.
// Per item: a received byte is stored if the buffer has room, then start
// positions are scanned one at a time, each with a setup step, then a
// read and a check for each of tag, length, command, id and up to four
// indication bytes. When a complete frame is found, a checksum pass reads
// its bytes, the bytes are then sent, and the remaining bytes are moved to
// the front. in_stall stays high from acceptance until the item is fully
// handled. Reset clears count, idle counter and control and zeroes all
// registers but the timeout; RAM contents are not cleared. A stalled
// output holds its byte and the sequencer waits.
module tagged_frame_deframer_checker
	import tfdc_pkg::*;
#(
	parameter int BUFFER_DEPTH = BufferDepthDef,
	parameter int MIN_FRAME = MinFrameDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  in_item_t            in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output out_item_t           out_data,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);
	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int CW = $clog2(BUFFER_DEPTH + 1);
	localparam logic [CW-1:0] DepthC = CW'(BUFFER_DEPTH);
	localparam logic [CW-1:0] MinC = CW'(MIN_FRAME);

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_SCAN  = 11'b00000000010,
		ST_RD    = 11'b00000000100,
		ST_CHK   = 11'b00000001000,
		ST_SUMRD = 11'b00000010000,
		ST_SUM   = 11'b00000100000,
		ST_EMRD  = 11'b00001000000,
		ST_EMIT  = 11'b00010000000,
		ST_MVRD  = 11'b00100000000,
		ST_MVWR  = 11'b01000000000,
		ST_END   = 11'b10000000000
	} state_t;

	state_t state_q;
	logic [7:0] req_tag_q, rsp_tag_q;
	logic any_tag_q;
	logic [4:0] ind_cmd_q;
	logic [15:0] timeout_q, idle_q;
	logic [CW-1:0] count_q, pos_q, k_q, mv_q;
	logic [3:0] off_q;
	logic [7:0] len_q, cmd_q, sum_q;
	logic found_q;

	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0] ram_wdata, rd;
	logic [CW-1:0] raddr_full, end_c;

	tfdc_ram #(.Width(8), .Depth(BUFFER_DEPTH)) u_buf (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(rd)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign end_c = pos_q + CW'(len_q);
	wire is_tag = (rd == req_tag_q) || (rd == rsp_tag_q);
	wire ind_frame = (len_q == IndLenA || len_q == IndLenB) && cmd_q[4:0] == ind_cmd_q;
	wire in_acc = in_valid && !in_stall;
	wire out_acc = out_valid && !out_stall;

	always_comb begin
		raddr_full = pos_q + CW'(off_q);
		case (state_q)
			ST_SUMRD, ST_EMRD: raddr_full = pos_q + k_q;
			ST_MVRD: raddr_full = end_c + mv_q;
			default: ;
		endcase
		ram_raddr = raddr_full[AW-1:0];
		ram_we = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = in_data.rx_byte;
		if (in_acc && in_data.operation == OP_BYTE && count_q < DepthC) begin
			ram_we = 1'b1;
		end
		if (state_q == ST_MVWR) begin
			ram_we = 1'b1;
			ram_waddr = mv_q[AW-1:0];
			ram_wdata = rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			req_tag_q <= '0; rsp_tag_q <= '0; any_tag_q <= 1'b0;
			ind_cmd_q <= '0; timeout_q <= 16'd1000;
			idle_q <= '0; count_q <= '0; pos_q <= '0; k_q <= '0; mv_q <= '0;
			off_q <= '0; len_q <= '0; cmd_q <= '0; sum_q <= '0;
			found_q <= 1'b0; out_valid <= 1'b0; out_data <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_REQ_TAG: req_tag_q <= cfg_data[7:0];
					CFG_RSP_TAG: rsp_tag_q <= cfg_data[7:0];
					CFG_ANY_TAG: any_tag_q <= cfg_data[0];
					CFG_IND_CMD: ind_cmd_q <= cfg_data[4:0];
					CFG_TIMEOUT: timeout_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_acc) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_acc) begin
					if (in_data.operation == OP_BYTE) begin
						idle_q <= '0;
						if (count_q < DepthC) count_q <= count_q + 1'b1;
					end else if (idle_q != 16'hFFFF) begin
						idle_q <= idle_q + 1'b1;
					end
					pos_q <= '0; off_q <= '0; found_q <= 1'b0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (count_q < MinC || pos_q + MinC > count_q) begin
						state_q <= ST_END;
					end else begin
						off_q <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_CHK;
				ST_CHK: begin
					logic fail;
					fail = 1'b0;
					case (off_q)
						4'd0: fail = !any_tag_q && !is_tag;
						4'd1: begin
							fail = rd >= 8'(LenLimit) || rd < 8'(MIN_FRAME);
							len_q <= rd;
						end
						4'd2: begin fail = rd >= CmdLimit; cmd_q <= rd; end
						4'd3: fail = rd >= IdLimit;
						default: fail = (pos_q + CW'(off_q) < count_q) && is_tag;
					endcase
					if (fail) begin
						pos_q <= pos_q + 1'b1;
						state_q <= ST_SCAN;
					end else if (off_q == 4'd7 || (off_q == 4'd3 && !ind_frame)) begin
						if (end_c > count_q) begin
							state_q <= ST_END;
						end else begin
							found_q <= 1'b1; k_q <= '0; sum_q <= '0;
							state_q <= ST_SUMRD;
						end
					end else begin
						off_q <= off_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_SUMRD: state_q <= ST_SUM;
				ST_SUM: begin
					if (k_q + 1'b1 < CW'(len_q)) begin
						sum_q <= sum_q + rd;
						k_q <= k_q + 1'b1;
						state_q <= ST_SUMRD;
					end else begin
						k_q <= '0;
						state_q <= ST_EMRD;
					end
				end
				ST_EMRD: if (!out_valid || out_acc) state_q <= ST_EMIT;
				ST_EMIT: begin
					out_valid <= 1'b1;
					out_data.frame_byte <= rd;
					out_data.frame_length <= len_q[4:0];
					out_data.last_byte <= (k_q + 1'b1 == CW'(len_q));
					out_data.checksum_ok <= (k_q + 1'b1 == CW'(len_q)) &&
						(8'(0) - sum_q == rd);
					if (k_q + 1'b1 == CW'(len_q)) begin
						mv_q <= '0;
						state_q <= ST_MVRD;
					end else begin
						k_q <= k_q + 1'b1;
						state_q <= ST_EMRD;
					end
				end
				ST_MVRD: begin
					if (end_c + mv_q >= count_q) begin
						count_q <= count_q - end_c;
						state_q <= ST_END;
					end else begin
						state_q <= ST_MVWR;
					end
				end
				ST_MVWR: begin
					mv_q <= mv_q + 1'b1;
					state_q <= ST_MVRD;
				end
				ST_END: begin
					if (!found_q && count_q != '0 && idle_q > timeout_q) count_q <= '0;
					if (!out_valid || out_acc) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
